// ===== hw/rtl/bvrp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bvrp_pkg: shared types and constants
// Item types, command classification and palette helpers for the banked
// video RAM block.
// ---------------------------------------------------------------------------
package bvrp_pkg;

	// Store geometry
	localparam int STORE_DEPTH = 8192;
	localparam int OFF_W       = 13;

	// Address map
	localparam logic [OFF_W-1:0] PALETTE_END   = 13'h0800;
	localparam logic [OFF_W-1:0] TILE_START    = 13'h1000;
	localparam logic [10:0]      BANK1_PALETTE = 11'h400;

	// Bus operation codes
	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_BANK_WR = 2'd2;

	typedef struct packed {
		logic [1:0]       operation;
		logic [OFF_W-1:0] offset;
		logic [7:0]       write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        palette_valid;
		logic [10:0] palette_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        dirty_valid;
		logic        dirty_layer;
		logic [10:0] dirty_tile;
	} res_item_t;

	// Classified command passed from front to back
	typedef enum logic [2:0] {
		K_READ,
		K_PAL_WR,
		K_TILE_WR,
		K_BANK_WR,
		K_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             pal_region;
		logic [OFF_W-1:0] offset;
		logic [7:0]       wdata;
		logic [10:0]      tile;
	} cmd_t;

	// Back-end sequencer
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESP
	} back_state_t;

	// 5-bit to 8-bit color expansion
	function automatic logic [7:0] expand5(input logic [4:0] v);
		expand5 = {v, v[4:2]};
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/banked_video_ram_palette.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// banked_video_ram_palette: banked video RAM with palette and dirty reporting
// Bus front end, command queue, access sequencer and result queue.
// ---------------------------------------------------------------------------
// Every accepted item gives exactly one result item. Set by the registered
// read port of the byte stores, the access sequencer writes and addresses
// the store in its idle state and forms the result from the read byte in
// its response state (an item that is not a read fetches the other byte of
// its pair). A new item is issued only after the last result is pushed.
// After reset both 8192-byte stores are cleared one address per cycle;
// full stays high while clearing. Input and result queues decouple both
// sides, so push is taken while earlier results still wait to be popped.
module banked_video_ram_palette #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  bvrp_pkg::in_item_t  request,
	output logic                empty,
	input  wire                 pop,
	output bvrp_pkg::res_item_t result
);
	import bvrp_pkg::*;

	logic      cmd_full;
	logic      cmd_push;
	cmd_t      cmd_in;
	cmd_t      cmd_out;
	logic      cmd_empty;
	logic      cmd_pop;
	logic      res_full;
	logic      res_push;
	res_item_t res_in;
	logic      clearing;

	assign full = cmd_full || clearing;

	bvrp_front u_front (
		.push     (push),
		.blocked  (full),
		.request  (request),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	bvrp_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	bvrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in),
		.clearing  (clearing)
	);

	bvrp_fifo #(.WIDTH($bits(res_item_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/bvrp_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bvrp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module bvrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bvrp_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bvrp_fifo: small synchronous queue
// Used between front and back and as the result queue.
// ---------------------------------------------------------------------------
module bvrp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wdata,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bvrp_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bvrp_front: item classifier
// Decodes the bus operation and address region and precomputes the tile
// index before the item enters the command queue.
// ---------------------------------------------------------------------------
module bvrp_front (
	input  wire                 push,
	input  wire                 blocked,
	input  bvrp_pkg::in_item_t  request,
	output logic                cmd_push,
	output bvrp_pkg::cmd_t      cmd
);
	import bvrp_pkg::*;

	logic             pal_region;
	logic [OFF_W-1:0] tile_lo;
	logic [OFF_W-1:0] tile_hi;

	assign cmd_push = push && !blocked;

	// region decode and tile index
	always_comb begin
		pal_region = (request.offset < PALETTE_END);
		tile_lo    = request.offset - PALETTE_END;
		tile_hi    = (request.offset - TILE_START) >> 1;
	end

	// classification
	always_comb begin
		cmd.pal_region = pal_region;
		cmd.offset     = request.offset;
		cmd.wdata      = request.write_data;
		cmd.tile       = (request.offset < TILE_START) ? tile_lo[10:0] : tile_hi[10:0];
		case (request.operation)
			OP_READ:    cmd.kind = K_READ;
			OP_WRITE:   cmd.kind = pal_region ? K_PAL_WR : K_TILE_WR;
			OP_BANK_WR: cmd.kind = K_BANK_WR;
			default:    cmd.kind = K_NOP;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bvrp_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bvrp_back: access sequencer
// Owns the bank register and both byte stores, clears the stores after
// reset, and turns each command into one result item.
// ---------------------------------------------------------------------------
module bvrp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	input  bvrp_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  wire                 res_full,
	output logic                res_push,
	output bvrp_pkg::res_item_t res,
	output logic                clearing
);
	import bvrp_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	back_state_t state_q;
	back_state_t state_d;
	logic [AW-1:0] clr_addr_q;
	logic [7:0]    bank_q;
	cmd_t          cur_q;
	logic          bank_bit_q;
	logic          issue;
	logic          bank_bit;

	logic          we_a;
	logic          we_b;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata_a;
	logic [7:0]    rdata_b;
	logic [7:0]    rbyte;
	logic [14:0]   word;

	assign issue    = (state_q == ST_IDLE) && cmd_valid && !res_full;
	assign bank_bit = cmd.pal_region ? bank_q[1] : bank_q[0];
	assign clearing = (state_q == ST_CLEAR);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (issue) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	// state outputs: queue handshakes and store ports
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		we_a     = 1'b0;
		we_b     = 1'b0;
		waddr    = cmd.offset;
		wdata    = cmd.wdata;
		raddr    = cmd.offset;
		case (state_q)
			ST_CLEAR: begin
				we_a  = 1'b1;
				we_b  = 1'b1;
				waddr = clr_addr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				cmd_pop = issue;
				if (cmd.kind != K_READ) begin
					// every command that is not a read fetches the other byte of its pair
					raddr = {cmd.offset[AW-1:1], ~cmd.offset[0]};
				end
				if (issue && (cmd.kind == K_PAL_WR || cmd.kind == K_TILE_WR)) begin
					we_a = bank_bit;
					we_b = !bank_bit;
				end
			end
			ST_RESP: res_push = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			bank_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (issue && cmd.kind == K_BANK_WR) begin
				bank_q <= cmd.wdata;
			end
		end
	end

	// command in flight
	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q      <= cmd;
			bank_bit_q <= bank_bit;
		end
	end

	bvrp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_a)
	);

	bvrp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_b)
	);

	// result assembly from the fetched byte
	always_comb begin
		rbyte = bank_bit_q ? rdata_a : rdata_b;
		if (cur_q.offset[0]) begin
			word = {cur_q.wdata[6:0], rbyte};
		end else begin
			word = {rbyte[6:0], cur_q.wdata};
		end
		res = '0;
		case (cur_q.kind)
			K_READ: res.read_data = rbyte;
			K_PAL_WR: begin
				res.palette_valid = 1'b1;
				res.palette_index = {1'b0, cur_q.offset[10:1]}
					+ (bank_bit_q ? BANK1_PALETTE : 11'd0);
				res.red   = expand5(word[4:0]);
				res.green = expand5(word[9:5]);
				res.blue  = expand5(word[14:10]);
			end
			K_TILE_WR: begin
				res.dirty_valid = 1'b1;
				res.dirty_layer = !bank_bit_q;
				res.dirty_tile  = cur_q.tile;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for banked_video_ram_palette
// Drives bus accesses through the request queue and checks every result item
// against a cycle-free model of the two banked stores, the bank register, the
// palette pairing and the tile-dirty mapping. Both sides stall at random.
// ---------------------------------------------------------------------------
module tb;
	import bvrp_pkg::*;

	// Code that the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Idle cycles with no item moving before the run is abandoned; the limit
	// covers the clearing pass after reset.
	localparam int QUIET_LIMIT  = 40000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int MAX_PRINTS   = 50;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  request;
	logic      empty;
	logic      pop;
	res_item_t result;

	// Model state: bank register and both byte stores (cleared at reset)
	logic [7:0] model_bank;
	bit   [7:0] model_store_a [0:STORE_DEPTH-1];
	bit   [7:0] model_store_b [0:STORE_DEPTH-1];

	res_item_t pending_results [$];
	int        error_count;
	int        quiet_cycles;
	int        pop_stall;
	bit        steady;

	banked_video_ram_palette u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// 5-bit color field to 8 bits, top bits repeated into the low end
	function automatic logic [7:0] widen5(logic [4:0] v);
		return {v, 3'b000} | 8'(v >> 2);
	endfunction

	// Predict the result of one access and update the model state
	function automatic res_item_t predict_access(in_item_t it);
		res_item_t   r;
		logic        sel;
		logic [12:0] even_off;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [14:0] bgr;
		r = '0;
		if (it.operation == OP_BANK_WR) begin
			model_bank = it.write_data;
		end else if (it.operation == OP_READ || it.operation == OP_WRITE) begin
			// palette region follows bank bit 1, the rest bank bit 0
			sel = (it.offset < PALETTE_END) ? model_bank[1] : model_bank[0];
			if (it.operation == OP_READ) begin
				r.read_data = sel ? model_store_a[it.offset] : model_store_b[it.offset];
			end else begin
				if (sel) model_store_a[it.offset] = it.write_data;
				else model_store_b[it.offset] = it.write_data;
				if (it.offset < PALETTE_END) begin
					even_off = {it.offset[12:1], 1'b0};
					lo = sel ? model_store_a[even_off] : model_store_b[even_off];
					hi = sel ? model_store_a[even_off + 13'd1] : model_store_b[even_off + 13'd1];
					bgr = {hi[6:0], lo};
					r.palette_valid = 1'b1;
					r.palette_index = 11'(it.offset >> 1) + (sel ? BANK1_PALETTE : 11'd0);
					r.red   = widen5(bgr[4:0]);
					r.green = widen5(bgr[9:5]);
					r.blue  = widen5(bgr[14:10]);
				end else begin
					r.dirty_valid = 1'b1;
					r.dirty_layer = ~sel;
					r.dirty_tile  = (it.offset < TILE_START) ?
						11'(it.offset - PALETTE_END) : 11'((it.offset - TILE_START) >> 1);
				end
			end
		end
		return r;
	endfunction

	function automatic in_item_t make_item(logic [1:0] op, logic [12:0] off, logic [7:0] data);
		in_item_t it;
		it.operation  = op;
		it.offset     = off;
		it.write_data = data;
		return it;
	endfunction

	// Gap length: mostly none or short, a few long
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_error(string msg);
		error_count++;
		if (error_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want) report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// Send one item: optional gap, then hold push until the block takes it
	task automatic send_item(in_item_t it);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push    = 1'b1;
		request = it;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_results.push_back(predict_access(it));
	endtask

	// Hold the sender until every expected result item has been popped
	task automatic wait_all_results();
		@(negedge clk);
		push = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Stores read back as zero after the clearing pass
	task automatic test_reset_contents();
		send_item(make_item(OP_READ, 13'h0000, 8'h00));
		send_item(make_item(OP_READ, 13'h1FFF, 8'hFF));
		send_item(make_item(OP_BANK_WR, 13'h0000, 8'hFF));
		send_item(make_item(OP_READ, 13'h07FF, 8'h00));
		send_item(make_item(OP_READ, 13'h0800, 8'h00));
	endtask

	// Palette pairing in both banks, bit 15 of the word ignored
	task automatic test_palette_pairs();
		send_item(make_item(OP_BANK_WR, 13'h0000, 8'h00));
		send_item(make_item(OP_WRITE, 13'h0000, 8'hFF));
		send_item(make_item(OP_WRITE, 13'h0001, 8'hFF));
		send_item(make_item(OP_READ, 13'h0001, 8'h00));
		send_item(make_item(OP_BANK_WR, 13'h1FFF, 8'h02));
		send_item(make_item(OP_WRITE, 13'h07FE, 8'h00));
		send_item(make_item(OP_WRITE, 13'h07FF, 8'h80));
		send_item(make_item(OP_READ, 13'h07FF, 8'h00));
	endtask

	// Colour RAM and tile RAM boundary addresses on both layers
	task automatic test_tile_writes();
		send_item(make_item(OP_BANK_WR, 13'h0000, 8'h01));
		send_item(make_item(OP_WRITE, 13'h0800, 8'hAA));
		send_item(make_item(OP_WRITE, 13'h0FFF, 8'h55));
		send_item(make_item(OP_BANK_WR, 13'h0000, 8'hFE));
		send_item(make_item(OP_WRITE, 13'h1000, 8'h00));
		send_item(make_item(OP_WRITE, 13'h1FFF, 8'hFF));
		send_item(make_item(OP_READ, 13'h1FFF, 8'h00));
	endtask

	// Unused operation code gives an all-zero result item
	task automatic test_ignored_ops();
		send_item(make_item(OP_UNUSED, 13'h1FFF, 8'hFF));
		send_item(make_item(OP_UNUSED, 13'h0000, 8'h00));
		send_item(make_item(OP_BANK_WR, 13'h0000, 8'h00));
	endtask

	// Random traffic: mostly write/readback sequences, some noise
	task automatic test_random_traffic();
		int          sent;
		int          kind;
		bit          paused;
		logic [12:0] off;
		logic [1:0]  op;
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			steady = ((sent / 250) % 4) == 3;
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_all_results();
				paused = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// palette pair write, then read back one byte
				if ($urandom_range(0, 3) == 0) begin
					send_item(make_item(OP_BANK_WR, 13'($urandom), 8'($urandom)));
					sent++;
				end
				off = 13'($urandom_range(0, 1023) * 2);
				send_item(make_item(OP_WRITE, off, 8'($urandom)));
				send_item(make_item(OP_WRITE, off | 13'd1, 8'($urandom)));
				send_item(make_item(OP_READ, off | 13'($urandom_range(0, 1)), 8'($urandom)));
				sent += 3;
			end else if (kind < 65) begin
				// colour or tile write and readback
				off = 13'($urandom_range(13'h0800, 13'h1FFF));
				send_item(make_item(OP_WRITE, off, 8'($urandom)));
				send_item(make_item(OP_READ, off, 8'($urandom)));
				sent += 2;
			end else if (kind < 75) begin
				send_item(make_item(OP_BANK_WR, 13'($urandom), 8'($urandom)));
				sent++;
			end else if (kind < 90) begin
				send_item(make_item(OP_READ, 13'($urandom), 8'($urandom)));
				sent++;
			end else if (kind < 95) begin
				send_item(make_item(OP_UNUSED, 13'($urandom), 8'($urandom)));
			end else begin
				op = 2'($urandom_range(0, 3));
				send_item(make_item(op, 13'($urandom), 8'($urandom)));
				if (op != OP_UNUSED) sent++;
			end
		end
		steady = 1'b0;
	endtask

	// Result side: random pop stalls, none while steady
	always @(negedge clk) begin
		if (!arst_n) begin
			pop = 1'b0;
		end else if (steady) begin
			pop = 1'b1;
		end else if (pop_stall > 0) begin
			pop = 1'b0;
			pop_stall--;
		end else begin
			pop = 1'b1;
			if ($urandom_range(0, 3) == 0) pop_stall = next_gap();
		end
	end

	// Compare each popped result item with the oldest expectation
	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result item with none expected: 0x%0h", result));
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", result.read_data, want.read_data);
				check_field("palette_valid", result.palette_valid, want.palette_valid);
				check_field("palette_index", result.palette_index, want.palette_index);
				check_field("red", result.red, want.red);
				check_field("green", result.green, want.green);
				check_field("blue", result.blue, want.blue);
				check_field("dirty_valid", result.dirty_valid, want.dirty_valid);
				check_field("dirty_layer", result.dirty_layer, want.dirty_layer);
				check_field("dirty_tile", result.dirty_tile, want.dirty_tile);
			end
		end
	end

	// Watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		request      = '0;
		model_bank   = '0;
		error_count  = 0;
		quiet_cycles = 0;
		pop_stall    = 0;
		steady       = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_palette_pairs();
		test_tile_writes();
		test_ignored_ops();
		test_random_traffic();

		// drain, then watch a little longer for stray result items
		wait_all_results();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
